// ===== rtl/qfs_pkg.sv =====
package qfs_pkg;

  // byte that opens and closes a quoted field
  localparam logic [7:0] QUOTE_BYTE = 8'h22;

  // output field widths
  localparam int START_W  = 10;
  localparam int LENGTH_W = 10;
  localparam int NUMBER_W = 6;

  // configuration register indexes
  localparam int CFG_INDEX_W = 2;
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DELIMITER_BYTES = 2'd0,
    REG_DELIMITER_COUNT = 2'd1,
    REG_SKIP_EMPTY      = 2'd2
  } cfg_reg_t;

  // configuration reset values: space and newline
  localparam logic [31:0] DELIMITER_BYTES_RST = 32'h0000_0A20;
  localparam logic [2:0]  DELIMITER_COUNT_RST = 3'd2;

  // one result item
  typedef struct packed {
    logic                present;
    logic [START_W-1:0]  start;
    logic [LENGTH_W-1:0] length;
    logic [NUMBER_W-1:0] number;
    logic                overflow;
    logic                done;
  } result_t;

endpackage

// ===== rtl/quoted_field_splitter.sv =====
// Splits a line of text, one byte per cycle, into fields at up to four
// configurable delimiter bytes, honoring double quotes, and reports start,
// length and index of each field. A byte is taken every cycle unless the
// input stalls: the byte is registered, decoded against the delimiters and
// the quote state in one pass, and its zero, one or two results go into a
// four-entry result queue. The input stalls only while that queue holds
// more than two results, so a receiver that takes one result per cycle
// never slows the byte stream down. The byte at offset LINE_LEN-1 and beyond
// is ignored except for its line end mark; at most MAX_FIELDS fields are
// reported per line, later ones raise the overflow flag of the line-end
// result. Configuration writes are always ready.
module quoted_field_splitter #(
  parameter int LINE_LEN   = 1024,
  parameter int MAX_FIELDS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  // byte channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       byte_value,
  input  logic                             line_end,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             field_present,
  output logic [qfs_pkg::START_W-1:0]      field_start,
  output logic [qfs_pkg::LENGTH_W-1:0]     field_length,
  output logic [qfs_pkg::NUMBER_W-1:0]     field_number,
  output logic                             field_overflow,
  output logic                             line_done,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [qfs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [31:0]                      cfg_data
);

  import qfs_pkg::*;

  localparam int PW = (LINE_LEN > 2) ? $clog2(LINE_LEN) : 1;
  localparam int FW = $clog2(MAX_FIELDS + 1);
  localparam logic [PW-1:0] LAST_POS = PW'(LINE_LEN - 1);
  localparam logic [FW-1:0] FIELD_LIMIT = FW'(MAX_FIELDS);

  // configuration registers
  logic [31:0] delimiter_bytes;
  logic [2:0]  delimiter_count;
  logic        skip_empty;

  // input register
  logic       inq_valid;
  logic [7:0] inq_byte;
  logic       inq_last;
  logic       proceed;

  // line state
  logic          quote_mode, quote_mode_next;
  logic [PW-1:0] field_begin, field_begin_next;
  logic          field_opens_quoted, field_opens_quoted_next;
  logic          close_pending, close_pending_next;
  logic [PW-1:0] close_position, close_position_next;
  logic [PW-1:0] byte_position, byte_position_next;
  logic [FW-1:0] fields_emitted;
  logic          dropped_flag;

  // result queue
  result_t     res_queue [4];
  logic [1:0]  rd_ptr;
  logic [1:0]  wr_ptr;
  logic [2:0]  count;
  logic        pop;
  logic [1:0]  push_n;
  result_t     push0, push1;

  // per-byte decode
  logic          active;
  logic          delim;
  logic          opens_quoted;
  logic          strip_now;
  logic          a_req, a_ok, b_req, b_ok;
  logic [PW-1:0] a_start, a_len, b_start, b_len, line_stop;
  logic [FW-1:0] fe_mid;
  logic          drop_mid;
  result_t       res_a, res_b, res_e;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter_bytes <= DELIMITER_BYTES_RST;
      delimiter_count <= DELIMITER_COUNT_RST;
      skip_empty      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DELIMITER_BYTES: delimiter_bytes <= cfg_data;
        REG_DELIMITER_COUNT: delimiter_count <= cfg_data[2:0];
        REG_SKIP_EMPTY:      skip_empty      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register, refilled in the cycle it drains
  assign proceed  = inq_valid && (count <= 3'd2);
  assign in_stall = inq_valid && !proceed;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      inq_valid <= 1'b1;
    end else if (proceed) begin
      inq_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      inq_byte <= byte_value;
      inq_last <= line_end;
    end
  end

  // delimiter match, entries equal to zero or quote are disabled
  always_comb begin
    delim = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if ((32'(delimiter_count) > i) && (delimiter_bytes[8*i +: 8] != 8'h00) &&
          (delimiter_bytes[8*i +: 8] != QUOTE_BYTE) &&
          (delimiter_bytes[8*i +: 8] == inq_byte)) begin
        delim = 1'b1;
      end
    end
  end

  // quote tracking and field boundaries for the registered byte
  always_comb begin
    active                  = byte_position < LAST_POS;
    quote_mode_next         = quote_mode;
    field_begin_next        = field_begin;
    field_opens_quoted_next = field_opens_quoted;
    close_pending_next      = close_pending;
    close_position_next     = close_position;
    byte_position_next      = byte_position;
    opens_quoted            = field_opens_quoted;
    strip_now               = 1'b0;
    a_req                   = 1'b0;
    a_start                 = field_begin;
    a_len                   = '0;

    if (active) begin
      if (byte_position == field_begin) begin
        opens_quoted = (inq_byte == QUOTE_BYTE);
      end
      field_opens_quoted_next = opens_quoted;
      if (close_pending) begin
        close_pending_next = 1'b0;
        strip_now          = delim;
      end
      if (quote_mode) begin
        if (inq_byte == QUOTE_BYTE) begin
          quote_mode_next = 1'b0;
          if (opens_quoted) begin
            close_pending_next  = 1'b1;
            close_position_next = byte_position;
          end
        end
      end else if (inq_byte == QUOTE_BYTE) begin
        quote_mode_next = 1'b1;
      end else if (delim) begin
        if (strip_now) begin
          a_req   = 1'b1;
          a_start = field_begin + PW'(1);
          a_len   = close_position - field_begin - PW'(1);
        end else if ((byte_position != field_begin) || !skip_empty) begin
          a_req   = 1'b1;
          a_start = field_begin;
          a_len   = byte_position - field_begin;
        end
        field_begin_next        = byte_position + PW'(1);
        field_opens_quoted_next = 1'b0;
      end
      byte_position_next = byte_position + PW'(1);
    end
  end

  // field emitted by a delimiter
  assign a_ok     = a_req && (fields_emitted < FIELD_LIMIT);
  assign fe_mid   = fields_emitted + FW'(a_ok);
  assign drop_mid = dropped_flag || (a_req && !a_ok);

  // field closed by the line end
  always_comb begin
    line_stop = byte_position_next;
    b_req     = 1'b0;
    b_start   = field_begin_next;
    b_len     = '0;
    if (inq_last) begin
      if (close_pending_next) begin
        b_req   = 1'b1;
        b_start = field_begin_next + PW'(1);
        b_len   = close_position_next - field_begin_next - PW'(1);
      end else if (line_stop != field_begin_next) begin
        b_req   = 1'b1;
        b_len   = line_stop - field_begin_next;
      end
    end
  end

  assign b_ok = b_req && (fe_mid < FIELD_LIMIT);

  // result items and their order in the queue
  always_comb begin
    res_a          = '0;
    res_a.present  = 1'b1;
    res_a.start    = START_W'(a_start);
    res_a.length   = LENGTH_W'(a_len);
    res_a.number   = NUMBER_W'(fields_emitted);
    res_a.overflow = dropped_flag;
    res_a.done     = inq_last && !b_ok;

    res_b          = '0;
    res_b.present  = 1'b1;
    res_b.start    = START_W'(b_start);
    res_b.length   = LENGTH_W'(b_len);
    res_b.number   = NUMBER_W'(fe_mid);
    res_b.overflow = drop_mid;
    res_b.done     = 1'b1;

    res_e          = '0;
    res_e.overflow = drop_mid || (b_req && !b_ok);
    res_e.done     = 1'b1;

    push0  = res_a;
    push1  = res_b;
    push_n = 2'd0;
    if (proceed) begin
      if (a_ok) begin
        push_n = b_ok ? 2'd2 : 2'd1;
      end else if (b_ok) begin
        push0  = res_b;
        push_n = 2'd1;
      end else if (inq_last) begin
        push0  = res_e;
        push_n = 2'd1;
      end
    end
  end

  // line state update, cleared after the last byte of a line
  always_ff @(posedge clk) begin
    if (rst) begin
      quote_mode         <= 1'b0;
      field_begin        <= '0;
      field_opens_quoted <= 1'b0;
      close_pending      <= 1'b0;
      close_position     <= '0;
      byte_position      <= '0;
      fields_emitted     <= '0;
      dropped_flag       <= 1'b0;
    end else if (proceed) begin
      if (inq_last) begin
        quote_mode         <= 1'b0;
        field_begin        <= '0;
        field_opens_quoted <= 1'b0;
        close_pending      <= 1'b0;
        close_position     <= '0;
        byte_position      <= '0;
        fields_emitted     <= '0;
        dropped_flag       <= 1'b0;
      end else begin
        quote_mode         <= quote_mode_next;
        field_begin        <= field_begin_next;
        field_opens_quoted <= field_opens_quoted_next;
        close_pending      <= close_pending_next;
        close_position     <= close_position_next;
        byte_position      <= byte_position_next;
        fields_emitted     <= fe_mid;
        dropped_flag       <= drop_mid;
      end
    end
  end

  // result queue
  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr + 2'(pop);
      wr_ptr <= wr_ptr + push_n;
      count  <= count + 3'(push_n) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      res_queue[wr_ptr] <= push0;
    end
    if (push_n == 2'd2) begin
      res_queue[wr_ptr + 2'd1] <= push1;
    end
  end

  assign field_present  = res_queue[rd_ptr].present;
  assign field_start    = res_queue[rd_ptr].start;
  assign field_length   = res_queue[rd_ptr].length;
  assign field_number   = res_queue[rd_ptr].number;
  assign field_overflow = res_queue[rd_ptr].overflow;
  assign line_done      = res_queue[rd_ptr].done;

endmodule

// ===== rtl/qfs_checker.sv =====
module qfs_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             field_present,
  input logic [qfs_pkg::START_W-1:0]      field_start,
  input logic [qfs_pkg::LENGTH_W-1:0]     field_length,
  input logic [qfs_pkg::NUMBER_W-1:0]     field_number,
  input logic                             field_overflow,
  input logic                             line_done
);

  // result queue is empty right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  // a stalled result stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // a stalled result keeps its payload
  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(field_present) && $stable(field_start) &&
      $stable(field_length) && $stable(field_number) &&
      $stable(field_overflow) && $stable(line_done))
    else $error("result payload changed while stalled");

  // a result without a field only closes a line and carries zero start, length and number
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !field_present |-> line_done && (field_start == '0) &&
      (field_length == '0) && (field_number == '0))
    else $error("malformed line-end result");

  // fields are dropped only after the last reported one
  a_no_overflow_on_field: assert property (@(posedge clk) disable iff (rst)
    out_valid && field_present |-> !field_overflow)
    else $error("reported field carries overflow");

endmodule

bind quoted_field_splitter qfs_checker chk (.*);

// ===== dv/quoted_field_splitter_test.sv =====
module quoted_field_splitter_test;
  import qfs_pkg::*;

  localparam int LINE_LEN     = 1024;
  localparam int MAX_FIELDS   = 64;
  localparam int RANDOM_ITEMS = 350;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;

  logic                   clk;
  logic                   rst        = 1'b1;
  logic                   in_valid   = 1'b0;
  logic                   in_stall;
  logic [7:0]             byte_value = 8'h00;
  logic                   line_end   = 1'b0;
  logic                   out_valid;
  logic                   out_stall  = 1'b0;
  logic                   field_present;
  logic [START_W-1:0]     field_start;
  logic [LENGTH_W-1:0]    field_length;
  logic [NUMBER_W-1:0]    field_number;
  logic                   field_overflow;
  logic                   line_done;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = REG_DELIMITER_BYTES;
  logic [31:0]            cfg_data   = 32'h0;

  quoted_field_splitter #(
    .LINE_LEN  (LINE_LEN),
    .MAX_FIELDS(MAX_FIELDS)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .byte_value    (byte_value),
    .line_end      (line_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .field_present (field_present),
    .field_start   (field_start),
    .field_length  (field_length),
    .field_number  (field_number),
    .field_overflow(field_overflow),
    .line_done     (line_done),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // splitter settings as the predictor sees them
  logic [31:0] delim_set;
  logic [2:0]  delim_used;
  logic        drop_empty;

  // per-line splitter state
  logic        line_in_quotes;
  int          cur_field_begin;
  logic        cur_opens_quoted;
  logic        strip_pending;
  int          strip_close_at;
  int          line_offset;
  int          fields_reported;
  logic        line_dropped;

  result_t     expected_fields[$];
  logic [7:0]  line_buf[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  logic        idling = 1'b1;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // random receiver stalls
  always @(negedge clk) begin
    out_stall <= idling && ($urandom_range(99) < 9);
  end

  function automatic void clear_line_state();
    line_in_quotes   = 1'b0;
    cur_field_begin  = 0;
    cur_opens_quoted = 1'b0;
    strip_pending    = 1'b0;
    strip_close_at   = 0;
    line_offset      = 0;
    fields_reported  = 0;
    line_dropped     = 1'b0;
  endfunction

  function automatic logic is_delim(logic [7:0] b);
    int         n;
    logic [7:0] d;
    logic       hit;
    n   = (delim_used > 3'd4) ? 4 : int'(delim_used);
    hit = 1'b0;
    for (int i = 0; i < n; i++) begin
      d = delim_set[8*i +: 8];
      if (d != 8'h00 && d != QUOTE_BYTE && d == b) hit = 1'b1;
    end
    return hit;
  endfunction

  // queue one field result unless the line already holds the maximum
  function automatic int report_field(int start, int len);
    result_t r;
    if (fields_reported >= MAX_FIELDS) begin
      line_dropped = 1'b1;
      return 0;
    end
    r.present  = 1'b1;
    r.start    = START_W'(start);
    r.length   = LENGTH_W'(len);
    r.number   = NUMBER_W'(fields_reported);
    r.overflow = line_dropped;
    r.done     = 1'b0;
    expected_fields.push_back(r);
    fields_reported++;
    return 1;
  endfunction

  // advance the splitter by one accepted byte and queue its results
  function automatic void split_byte(logic [7:0] b, logic is_last);
    int      pos;
    int      k;
    logic    delim;
    logic    strip;
    result_t r;
    pos = line_offset;
    k   = 0;
    if (pos < LINE_LEN - 1) begin
      delim = is_delim(b);
      strip = 1'b0;
      if (pos == cur_field_begin) cur_opens_quoted = (b == QUOTE_BYTE);
      if (strip_pending) begin
        strip_pending = 1'b0;
        strip = delim;
      end
      if (line_in_quotes) begin
        if (b == QUOTE_BYTE) begin
          line_in_quotes = 1'b0;
          if (cur_opens_quoted) begin
            strip_pending  = 1'b1;
            strip_close_at = pos;
          end
        end
      end else if (b == QUOTE_BYTE) begin
        line_in_quotes = 1'b1;
      end else if (delim) begin
        if (strip)
          k += report_field(cur_field_begin + 1, strip_close_at - cur_field_begin - 1);
        else if (pos != cur_field_begin || !drop_empty)
          k += report_field(cur_field_begin, pos - cur_field_begin);
        cur_field_begin  = pos + 1;
        cur_opens_quoted = 1'b0;
      end
      line_offset = pos + 1;
    end
    if (is_last) begin
      if (strip_pending)
        k += report_field(cur_field_begin + 1, strip_close_at - cur_field_begin - 1);
      else if (line_offset != cur_field_begin)
        k += report_field(cur_field_begin, line_offset - cur_field_begin);
      if (k > 0) begin
        r = expected_fields.pop_back();
        r.done = 1'b1;
        expected_fields.push_back(r);
      end else begin
        r          = '0;
        r.overflow = line_dropped;
        r.done     = 1'b1;
        expected_fields.push_back(r);
      end
      clear_line_state();
    end
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // compare each result transfer with the oldest expected field
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_fields.size() == 0) begin
        $error("result with no field expected: start %0d length %0d", field_start,
               field_length);
        mismatches++;
      end else begin
        want = expected_fields.pop_front();
        check_field("field_present", want.present, field_present);
        check_field("field_start", want.start, field_start);
        check_field("field_length", want.length, field_length);
        check_field("field_number", want.number, field_number);
        check_field("field_overflow", want.overflow, field_overflow);
        check_field("line_done", want.done, line_done);
      end
    end
  end

  // hold the byte channel until every expected field has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_fields.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DELIMITER_BYTES: delim_set  = value;
      REG_DELIMITER_COUNT: delim_used = value[2:0];
      REG_SKIP_EMPTY:      drop_empty = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_settings(logic [31:0] delims, logic [2:0] count, logic skip);
    write_reg(REG_DELIMITER_BYTES, delims);
    write_reg(REG_DELIMITER_COUNT, {29'h0, count});
    write_reg(REG_SKIP_EMPTY, {31'h0, skip});
  endtask

  // one byte transfer, with random gaps in front
  task automatic send_byte(logic [7:0] b, logic is_last);
    while (idling && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    byte_value <= b;
    line_end   <= is_last;
    do @(posedge clk); while (in_stall);
    split_byte(b, is_last);
    @(negedge clk);
  endtask

  // send line_buf as one line, optionally draining before byte pause_at
  task automatic send_line(int pause_at);
    for (int i = 0; i < line_buf.size(); i++) begin
      if (i == pause_at) wait_drained();
      send_byte(line_buf[i], i == line_buf.size() - 1);
    end
  endtask

  task automatic send_text(string s);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    send_line(-1);
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do begin
      b = ($urandom_range(1) == 0) ? 8'($urandom_range(8'h61, 8'h7A)) : 8'($urandom);
    end while (is_delim(b) || b == QUOTE_BYTE);
    return b;
  endfunction

  function automatic logic [7:0] pick_delim();
    logic [7:0] pool[$];
    logic [7:0] d;
    int         n;
    n = (delim_used > 3'd4) ? 4 : int'(delim_used);
    for (int i = 0; i < n; i++) begin
      d = delim_set[8*i +: 8];
      if (d != 8'h00 && d != QUOTE_BYTE) pool.push_back(d);
    end
    if (pool.size() == 0) return 8'h2C;
    return pool[$urandom_range(pool.size() - 1)];
  endfunction

  function automatic logic [7:0] noise_byte();
    int pick;
    pick = $urandom_range(9);
    if (pick < 3) return QUOTE_BYTE;
    if (pick < 6) return pick_delim();
    return 8'($urandom);
  endfunction

  // mostly well-formed lines of plain and quoted fields, some pure noise
  function automatic void make_random_line();
    int nfields;
    int kind;
    int len;
    line_buf.delete();
    if ($urandom_range(99) < 12) begin
      len = $urandom_range(1, 24);
      repeat (len) line_buf.push_back(noise_byte());
    end else begin
      nfields = ($urandom_range(99) < 3) ? $urandom_range(60, 70) : $urandom_range(1, 6);
      for (int f = 0; f < nfields; f++) begin
        if (f != 0) begin
          line_buf.push_back(pick_delim());
          if ($urandom_range(99) < 15) line_buf.push_back(pick_delim());
        end
        kind = $urandom_range(9);
        len  = $urandom_range(0, 6);
        if (kind < 5) begin
          repeat (len) line_buf.push_back(text_byte());
        end else if (kind < 8) begin
          // quoted field, delimiters inside are plain text
          line_buf.push_back(QUOTE_BYTE);
          repeat (len)
            line_buf.push_back(($urandom_range(3) == 0) ? pick_delim() : text_byte());
          line_buf.push_back(QUOTE_BYTE);
        end else if (kind == 8) begin
          // closing quote followed by text keeps its quotes
          line_buf.push_back(QUOTE_BYTE);
          repeat (len) line_buf.push_back(text_byte());
          line_buf.push_back(QUOTE_BYTE);
          line_buf.push_back(text_byte());
        end else begin
          // stray or unterminated quote
          line_buf.push_back(text_byte());
          line_buf.push_back(QUOTE_BYTE);
          repeat (len) line_buf.push_back(text_byte());
        end
      end
      if ($urandom_range(99) < 15) line_buf.push_back(pick_delim());
    end
    if (line_buf.size() == 0) line_buf.push_back(text_byte());
  endfunction

  task automatic random_settings();
    logic [31:0] delims;
    logic [31:0] count;
    logic [31:0] skip;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(7))
        0:       delims[8*i +: 8] = 8'h20;
        1:       delims[8*i +: 8] = 8'h2C;
        2:       delims[8*i +: 8] = 8'h3B;
        3:       delims[8*i +: 8] = 8'h0A;
        4:       delims[8*i +: 8] = 8'h00;
        5:       delims[8*i +: 8] = QUOTE_BYTE;
        6:       delims[8*i +: 8] = 8'hFF;
        default: delims[8*i +: 8] = 8'($urandom);
      endcase
    end
    count = ($urandom_range(9) < 8) ? $urandom_range(1, 4) : $urandom_range(0, 7);
    skip  = $urandom_range(1);
    // unused upper data bits now and then
    if ($urandom_range(1) == 1) begin
      count |= $urandom & 32'hFFFF_FFF8;
      skip  |= $urandom & 32'hFFFF_FFFE;
    end
    write_reg(REG_DELIMITER_BYTES, delims);
    write_reg(REG_DELIMITER_COUNT, count);
    write_reg(REG_SKIP_EMPTY, skip);
  endtask

  // plain fields with the reset delimiters
  task automatic test_plain_fields();
    send_text("ab cd");
    send_text("  x\ny");
    send_text("end ");
    send_text("q");
    send_text(" ");
    wait_drained();
  endtask

  // quote handling, quoted empty fields and empty-field suppression
  task automatic test_quoted_fields();
    send_text("\"a b\" c");
    send_text("\"\"");
    send_text("\"ab\"x y");
    send_text("\"abc d");
    send_text("a\"b c\"d e");
    write_reg(REG_SKIP_EMPTY, 32'h1);
    send_text(" \"\"  z ");
    send_text(" ");
    write_reg(REG_SKIP_EMPTY, 32'h0);
  endtask

  // delimiter table corners: disabled entries, count out of range, zero bytes
  task automatic test_delimiter_settings();
    write_settings(32'h00FF_222C, 3'd4, 1'b0);
    line_buf = '{8'h61, 8'h2C, 8'h00, 8'hFF, 8'h22, 8'h62, 8'h22, 8'h2C, 8'h2C};
    send_line(-1);
    write_reg(REG_DELIMITER_COUNT, 32'h0);
    send_text("a b,c");
    write_settings(32'hFFFF_FFFF, 3'd7, 1'b1);
    line_buf = '{8'hFF, 8'h61, 8'hFF, 8'hFF, 8'h00, 8'hFF};
    send_line(-1);
    write_reg(REG_SKIP_EMPTY, 32'h0);
    line_buf = '{8'hFF, 8'h61, 8'hFF, 8'hFF, 8'h00};
    send_line(-1);
    write_settings(32'h0000_0000, 3'd4, 1'b0);
    send_text("x y");
  endtask

  // exactly the maximum number of fields, then more than that
  task automatic test_field_overflow();
    write_settings(DELIMITER_BYTES_RST, DELIMITER_COUNT_RST, 1'b0);
    line_buf.delete();
    for (int i = 0; i < MAX_FIELDS; i++) begin
      if (i != 0) line_buf.push_back(8'h20);
      line_buf.push_back(8'h78);
    end
    send_line(-1);
    line_buf.delete();
    repeat (MAX_FIELDS + 6) begin
      line_buf.push_back(8'h78);
      line_buf.push_back(8'h20);
    end
    send_line(-1);
    send_text("k \"m\" n");
    wait_drained();
  endtask

  // line longer than the limit, closing quote on the last byte taken
  task automatic test_line_limit();
    logic [7:0] b;
    line_buf.delete();
    for (int i = 0; i < LINE_LEN + 6; i++) begin
      if (i == 700 || i == 1000)
        b = 8'h20;
      else if (i == 1001 || i == LINE_LEN - 2)
        b = QUOTE_BYTE;
      else
        b = 8'h61 + 8'(i % 26);
      line_buf.push_back(b);
    end
    send_line(-1);
    wait_drained();
  endtask

  task automatic test_random_lines();
    int sent;
    int lines;
    sent  = 0;
    lines = 0;
    while (sent < RANDOM_ITEMS) begin
      if (lines % 4 == 0) random_settings();
      idling = !(sent >= 100 && sent < 300);
      make_random_line();
      send_line((lines % 7 == 3) ? line_buf.size() / 2 : -1);
      sent += line_buf.size();
      lines++;
    end
    idling = 1'b1;
  endtask

  initial begin
    delim_set  = DELIMITER_BYTES_RST;
    delim_used = DELIMITER_COUNT_RST;
    drop_empty = 1'b0;
    clear_line_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_plain_fields();
    test_quoted_fields();
    test_delimiter_settings();
    test_field_overflow();
    test_line_limit();
    test_random_lines();
    wait_drained();
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
